// ===== src/assert_macros.svh =====
// Assertion macros for the checker file obb_sat_checker.sv.
// Each macro names a property, samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/obb_sat_pkg.sv =====
// Package for the oriented box separating axis test.
// Holds the sequencer state type and the command and status structs; no dependencies.
`default_nettype none

package obb_sat_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_I,
    ST_EDGE_J,
    ST_AXIS,
    ST_PROJ,
    ST_DRAIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;      // store the incoming corner
    logic rd_en;      // read one corner from the store
    logic rd_box;     // box of the corner being read
    logic proj;       // the read feeds the projection pipeline
    logic first;      // first corner of its box on this axis
    logic cap_i;      // capture the start point of the edge
    logic load_axis;  // form the axis from the edge end points
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;       // projection pipeline still holds corners
    logic separated;  // the intervals on the current axis do not overlap
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/obb_sat_corner_if.sv =====
// Input channel carrying one box corner per beat.
// Stand-alone interface; no dependencies.
`default_nettype none

interface obb_sat_corner_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         box_select;
  logic [1:0]                   corner_index;
  logic signed [COORD_BITS-1:0] corner_x;
  logic signed [COORD_BITS-1:0] corner_y;
  logic                         run_test;

  modport source (
    output valid, box_select, corner_index, corner_x, corner_y, run_test,
    input  ready
  );
  modport sink (
    input  valid, box_select, corner_index, corner_x, corner_y, run_test,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/obb_sat_result_if.sv =====
// Result channel carrying one collision verdict per beat.
// Stand-alone interface; no dependencies.
`default_nettype none

interface obb_sat_result_if ();
  logic valid;
  logic ready;
  logic colliding;

  modport source (output valid, colliding, input ready);
  modport sink   (input valid, colliding, output ready);
endinterface

`default_nettype wire

// ===== src/obb_sat_dp.sv =====
// Datapath: corner store, axis registers, projection pipeline and interval tracking.
// Depends on obb_sat_pkg for the command and status structs.
`default_nettype none

module obb_sat_dp #(
  parameter int NUM_CORNERS = 4,
  parameter int COORD_BITS  = 16,
  parameter int IW          = $clog2(NUM_CORNERS)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  obb_sat_pkg::dp_cmd_t         cmd,
  input  wire [IW-1:0]                 rd_idx,
  input  wire                          wr_box,
  input  wire [IW-1:0]                 wr_idx,
  input  wire signed [COORD_BITS-1:0]  wr_x,
  input  wire signed [COORD_BITS-1:0]  wr_y,
  output obb_sat_pkg::dp_sts_t         sts
);
  import obb_sat_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AXW = C + 1;
  localparam int PRW = 2 * C + 1;
  localparam int PJW = 2 * C + 2;

  // Corner store: x in the upper half of each word, y in the lower half.
  logic [2*C-1:0] mem [2][NUM_CORNERS];
  logic [2*C-1:0] rd_data_r;

  logic signed [C-1:0] rd_x;
  logic signed [C-1:0] rd_y;

  logic signed [C-1:0]   ei_x_r, ei_y_r;
  logic signed [AXW-1:0] ax_x_r, ax_y_r;
  logic signed [PRW-1:0] px_r, py_r;
  logic signed [PJW-1:0] sum_r;
  logic signed [PJW-1:0] amin_r, amax_r, bmin_r, bmax_r;

  logic v1_r, v2_r, v3_r;
  logic box1_r, box2_r, box3_r;
  logic first1_r, first2_r, first3_r;

  assign rd_x = $signed(rd_data_r[2*C-1:C]);
  assign rd_y = $signed(rd_data_r[C-1:0]);

  // Store write on an accepted beat, registered read for the sequencer.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_box][wr_idx] <= {wr_x, wr_y};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_box][rd_idx];
    end
  end

  // Edge start point and the edge normal (-dy, dx).
  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      ei_x_r <= rd_x;
      ei_y_r <= rd_y;
    end
    if (cmd.load_axis) begin
      ax_x_r <= {ei_y_r[C-1], ei_y_r} - {rd_y[C-1], rd_y};
      ax_y_r <= {rd_x[C-1], rd_x} - {ei_x_r[C-1], ei_x_r};
    end
  end

  // Valid, box and first-corner tags that travel with each projected corner.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en && cmd.proj;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    box1_r   <= cmd.rd_box;
    first1_r <= cmd.first;
    box2_r   <= box1_r;
    first2_r <= first1_r;
    box3_r   <= box2_r;
    first3_r <= first2_r;
  end

  // Products, then their sum: the exact dot product of axis and corner.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      px_r <= ax_x_r * rd_x;
      py_r <= ax_y_r * rd_y;
    end
    if (v2_r) begin
      sum_r <= {px_r[PRW-1], px_r} + {py_r[PRW-1], py_r};
    end
  end

  // Running minimum and maximum of each box's projections.
  always_ff @(posedge clk) begin
    if (v3_r) begin
      if (box3_r) begin
        if (first3_r || (sum_r > bmax_r)) bmax_r <= sum_r;
        if (first3_r || (sum_r < bmin_r)) bmin_r <= sum_r;
      end else begin
        if (first3_r || (sum_r > amax_r)) amax_r <= sum_r;
        if (first3_r || (sum_r < amin_r)) amin_r <= sum_r;
      end
    end
  end

  // Touching intervals overlap; only a strict gap separates.
  always_comb begin
    sts.busy      = v1_r || v2_r || v3_r;
    sts.separated = (amax_r < bmin_r) || (bmax_r < amin_r);
  end

endmodule

`default_nettype wire

// ===== src/obb_sat_ctrl.sv =====
// Controller: input handshake, axis and corner sequencing, result register.
// Depends on obb_sat_pkg for the state type and the command and status structs.
`default_nettype none

module obb_sat_ctrl #(
  parameter int NUM_CORNERS = 4,
  parameter int IW          = $clog2(NUM_CORNERS)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire [1:0]             in_corner_index,
  input  wire                   in_run_test,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_colliding,
  output obb_sat_pkg::dp_cmd_t  cmd,
  output logic [IW-1:0]         rd_idx,
  input  obb_sat_pkg::dp_sts_t  sts
);
  import obb_sat_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CORNERS - 1);

  state_t state_r, state_nxt;

  logic          axis_box_r, axis_box_nxt;
  logic [IW-1:0] axis_idx_r, axis_idx_nxt;
  logic          prj_box_r, prj_box_nxt;
  logic [IW-1:0] prj_idx_r, prj_idx_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          colliding_r;

  logic          accept;
  logic          idx_in_range;
  logic          last_axis;
  logic          out_load;
  logic [IW-1:0] edge_j_idx;

  assign accept       = in_valid && in_ready;
  assign idx_in_range = 32'(in_corner_index) < NUM_CORNERS;
  assign last_axis    = axis_box_r && (axis_idx_r == LAST_IDX);
  assign edge_j_idx   = (axis_idx_r == LAST_IDX) ? '0 : axis_idx_r + IW'(1);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept && in_run_test) state_nxt = ST_EDGE_I;
      ST_EDGE_I: state_nxt = ST_EDGE_J;
      ST_EDGE_J: state_nxt = ST_AXIS;
      ST_AXIS:   state_nxt = ST_PROJ;
      ST_PROJ:   if (prj_box_r && (prj_idx_r == LAST_IDX)) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!sts.busy) state_nxt = ST_CHECK;
      ST_CHECK:  begin
        if (sts.separated || last_axis) state_nxt = ST_DONE;
        else state_nxt = ST_EDGE_I;
      end
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath and the input handshake.
  always_comb begin
    cmd      = '0;
    rd_idx   = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.wr_en  = in_valid && idx_in_range;
      end
      ST_EDGE_I: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_box = axis_box_r;
        rd_idx     = axis_idx_r;
      end
      ST_EDGE_J: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_box = axis_box_r;
        cmd.cap_i  = 1'b1;
        rd_idx     = edge_j_idx;
      end
      ST_AXIS: begin
        cmd.load_axis = 1'b1;
      end
      ST_PROJ: begin
        cmd.rd_en  = 1'b1;
        cmd.proj   = 1'b1;
        cmd.rd_box = prj_box_r;
        cmd.first  = (prj_idx_r == '0);
        rd_idx     = prj_idx_r;
      end
      ST_DRAIN, ST_CHECK, ST_DONE: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Axis and corner counters, verdict and output register.
  always_comb begin
    axis_box_nxt  = axis_box_r;
    axis_idx_nxt  = axis_idx_r;
    prj_box_nxt   = prj_box_r;
    prj_idx_nxt   = prj_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;

    if ((state_r == ST_IDLE) && accept && in_run_test) begin
      axis_box_nxt = 1'b0;
      axis_idx_nxt = '0;
    end

    // The corner walk restarts at box 0, corner 0 for each axis.
    if (state_r == ST_AXIS) begin
      prj_box_nxt = 1'b0;
      prj_idx_nxt = '0;
    end
    if (state_r == ST_PROJ) begin
      if (prj_idx_r == LAST_IDX) begin
        prj_idx_nxt = '0;
        prj_box_nxt = 1'b1;
      end else begin
        prj_idx_nxt = prj_idx_r + IW'(1);
      end
    end

    if (state_r == ST_CHECK) begin
      res_nxt = !sts.separated;
      if (axis_idx_r == LAST_IDX) begin
        axis_idx_nxt = '0;
        axis_box_nxt = 1'b1;
      end else begin
        axis_idx_nxt = axis_idx_r + IW'(1);
      end
    end

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_box_r <= axis_box_nxt;
    axis_idx_r <= axis_idx_nxt;
    prj_box_r  <= prj_box_nxt;
    prj_idx_r  <= prj_idx_nxt;
    res_r      <= res_nxt;
    if (out_load) colliding_r <= res_r;
  end

  assign out_valid     = out_valid_r;
  assign out_colliding = colliding_r;

endmodule

`default_nettype wire

// ===== src/obb_separating_axis_test.sv =====
// Top level of the oriented box separating axis test: controller plus datapath.
// Depends on obb_sat_pkg, obb_sat_corner_if, obb_sat_result_if, obb_sat_ctrl, obb_sat_dp.
//
//   channel     dir  beat contents
//   in_corner   in   box_select, corner_index, corner_x, corner_y, run_test
//   out_result  out  colliding
//
// A corner beat without run_test is taken and stored.
// A beat with run_test stores its corner, then the test walks 2*NUM_CORNERS axes;
// each axis reads its edge ends, then all 2*NUM_CORNERS corners, via the single read port
// of the corner store and four-stage projection pipeline; the walk stops at the first gap.
// Reset is synchronous, active low, and clears the sequencer and the output valid.
// Corners are taken while a verdict waits in the output register; a finished test
// waits for that register to empty before the next test's verdict is loaded.
`default_nettype none

module obb_separating_axis_test #(
  parameter int NUM_CORNERS = 4,
  parameter int COORD_BITS  = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  obb_sat_corner_if.sink     in_corner,
  obb_sat_result_if.source   out_result
);
  import obb_sat_pkg::*;

  localparam int IW = $clog2(NUM_CORNERS);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [IW-1:0] rd_idx;

  obb_sat_ctrl #(
    .NUM_CORNERS (NUM_CORNERS),
    .IW          (IW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_corner.valid),
    .in_corner_index (in_corner.corner_index),
    .in_run_test     (in_corner.run_test),
    .in_ready        (in_corner.ready),
    .out_valid       (out_result.valid),
    .out_ready       (out_result.ready),
    .out_colliding   (out_result.colliding),
    .cmd             (cmd),
    .rd_idx          (rd_idx),
    .sts             (sts)
  );

  obb_sat_dp #(
    .NUM_CORNERS (NUM_CORNERS),
    .COORD_BITS  (COORD_BITS),
    .IW          (IW)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .rd_idx (rd_idx),
    .wr_box (in_corner.box_select),
    .wr_idx (IW'(in_corner.corner_index)),
    .wr_x   (in_corner.corner_x[COORD_BITS-1:0]),
    .wr_y   (in_corner.corner_y[COORD_BITS-1:0]),
    .sts    (sts)
  );

endmodule

`default_nettype wire

// ===== src/obb_sat_checker.sv =====
// Port-level checks for obb_separating_axis_test and the bind that attaches them.
// Depends on assert_macros.svh and the top level's interface ports.
`default_nettype none
`include "assert_macros.svh"

module obb_sat_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire in_run_test,
  input wire out_valid,
  input wire out_ready,
  input wire out_colliding
);

  // A stalled verdict stays offered and unchanged.
  `OBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `OBB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_colliding))

  // Once a test starts, the input side is closed on the next cycle.
  `OBB_ASSERT_NEXT(a_test_blocks_input, in_valid && in_ready && in_run_test, !in_ready)

  // A new verdict only appears after a test held the input side closed.
  `OBB_ASSERT_SAME(a_verdict_after_test, $rose(out_valid), $past(!in_ready))

endmodule

bind obb_separating_axis_test obb_sat_checker u_obb_sat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_corner.valid),
  .in_ready      (in_corner.ready),
  .in_run_test   (in_corner.run_test),
  .out_valid     (out_result.valid),
  .out_ready     (out_result.ready),
  .out_colliding (out_result.colliding)
);

`default_nettype wire

// ===== verif/obb_separating_axis_test_test.sv =====
// Self-checking testbench for the oriented box separating axis test.
// Uses obb_sat_corner_if, obb_sat_result_if and obb_separating_axis_test from src.
// Random box pairs, noise beats and stalls on both channels, with an exact integer predictor.

module obb_separating_axis_test_test;

  localparam int NUM_CORNERS  = 4;
  localparam int COORD_BITS   = 16;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_AT     = 700;

  // One corner beat as queued for the driver.
  typedef struct {
    bit                          box;
    bit [1:0]                    corner;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                          run;
    bit                          hold_for_drain;
  } corner_item_t;

  logic clk = 1'b0;
  logic rst_n;

  obb_sat_corner_if #(.COORD_BITS(COORD_BITS)) corner_ch ();
  obb_sat_result_if result_ch ();

  obb_separating_axis_test #(
    .NUM_CORNERS(NUM_CORNERS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_corner (corner_ch),
    .out_result(result_ch)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  corner_item_t corner_q[$];
  bit           verdict_q[$];

  // Predictor copy of the corner store.
  logic signed [COORD_BITS-1:0] held_x [2][NUM_CORNERS];
  logic signed [COORD_BITS-1:0] held_y [2][NUM_CORNERS];

  // Planned box corners used while building stimulus.
  int plan_x [2][NUM_CORNERS];
  int plan_y [2][NUM_CORNERS];

  int  cycle_count  = 0;
  int  beats_taken  = 0;
  int  mismatches   = 0;
  int  tx_gap       = 0;
  int  rx_gap       = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  corner_taken = 1'b0;
  bit  drain_marked = 1'b0;

  // True when no edge of either box separates the projected intervals.
  function automatic bit boxes_overlap();
    longint ax, ay, p;
    longint lo [2];
    longint hi [2];
    int b, i, j, k, c;
    for (b = 0; b < 2; b++) begin
      for (i = 0; i < NUM_CORNERS; i++) begin
        j  = (i + 1) % NUM_CORNERS;
        ax = -(longint'(held_y[b][j]) - longint'(held_y[b][i]));
        ay = longint'(held_x[b][j]) - longint'(held_x[b][i]);
        for (k = 0; k < 2; k++) begin
          for (c = 0; c < NUM_CORNERS; c++) begin
            p = ax * longint'(held_x[k][c]) + ay * longint'(held_y[k][c]);
            if (c == 0 || p < lo[k]) lo[k] = p;
            if (c == 0 || p > hi[k]) hi[k] = p;
          end
        end
        if (hi[0] < lo[1] || hi[1] < lo[0]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] to_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Idling is off in quiet windows and in the tail of the run.
  function automatic bit idling_allowed();
    return corner_q.size() > QUIET_TAIL && ((cycle_count / 256) % 3) != 0;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic push_corner(input bit box, input int idx, input int x, input int y,
                             input bit run);
    corner_item_t it;
    it.box            = box;
    it.corner         = idx[1:0];
    it.x              = to_coord(x);
    it.y              = to_coord(y);
    it.run            = run;
    it.hold_for_drain = 1'b0;
    corner_q          = {corner_q, it};
  endtask

  // Rectangle spanned by the direction (ux, uy) and its perpendicular,
  // corners listed in order around the box.
  task automatic plan_box(input int b, input int cx, input int cy, input int ux,
                          input int uy, input int ha, input int hb);
    int sa [4];
    int sb [4];
    int k;
    sa = '{1, -1, -1, 1};
    sb = '{1, 1, -1, -1};
    for (k = 0; k < NUM_CORNERS; k++) begin
      plan_x[b][k] = cx + sa[k] * ha * ux - sb[k] * hb * uy;
      plan_y[b][k] = cy + sa[k] * ha * uy + sb[k] * hb * ux;
    end
  endtask

  // One well-formed test: new box pair in random order, or one box anew; run on the last.
  task automatic queue_box_pair();
    int b, k, t, tmp, pick, span, ux, uy, ha, hb, mode;
    int reach [2];
    int cx [2];
    int cy [2];
    int order [8];
    pick = $urandom_range(0, 9);
    span = (pick < 6) ? 40 : (pick < 9) ? 400 : 1900;
    for (b = 0; b < 2; b++) begin
      ux = int'($urandom_range(0, 16)) - 8;
      uy = int'($urandom_range(0, 16)) - 8;
      if (ux == 0 && uy == 0) ux = 1;
      ha = $urandom_range(1, span);
      hb = $urandom_range(1, span);
      reach[b] = ((ux < 0) ? -ux : ux) + ((uy < 0) ? -uy : uy);
      reach[b] = reach[b] * (ha > hb ? ha : hb);
      if (b == 0) begin
        cx[0] = spread((pick >= 6 && pick < 9) ? 12000 : 2000);
        cy[0] = spread((pick >= 6 && pick < 9) ? 12000 : 2000);
      end else begin
        cx[1] = cx[0] + spread(reach[0] + reach[1] + 8);
        cy[1] = cy[0] + spread(reach[0] + reach[1] + 8);
      end
      plan_box(b, cx[b], cy[b], ux, uy, ha, hb);
      // Now and then collapse one edge to a point.
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, NUM_CORNERS - 1);
        plan_x[b][(k + 1) % NUM_CORNERS] = plan_x[b][k];
        plan_y[b][(k + 1) % NUM_CORNERS] = plan_y[b][k];
      end
    end
    mode = $urandom_range(0, 19);
    if (mode < 15) begin
      for (k = 0; k < 8; k++) order[k] = k;
      for (k = 7; k > 0; k--) begin
        t        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[t];
        order[t] = tmp;
      end
      for (k = 0; k < 8; k++) begin
        b = order[k] / NUM_CORNERS;
        t = order[k] % NUM_CORNERS;
        push_corner(b, t, plan_x[b][t], plan_y[b][t], k == 7);
        if (k == 0 && !drain_marked && corner_q.size() >= DRAIN_AT) begin
          corner_q[$].hold_for_drain = 1'b1;
          drain_marked = 1'b1;
        end
      end
    end else begin
      // Replace only one box and rerun against the stored other box.
      b = $urandom_range(0, 1);
      for (k = 0; k < NUM_CORNERS; k++)
        push_corner(b, k, plan_x[b][k], plan_y[b][k], k == NUM_CORNERS - 1);
    end
  endtask

  // Cycle counter and overall time limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("obb_separating_axis_test_test: done, errors");
      $finish;
    end
  end

  // Monitor: check verdict beats, then update the predictor with corner beats.
  always @(posedge clk) begin
    bit want;
    corner_taken = rst_n && corner_ch.valid && corner_ch.ready;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (verdict_q.size() == 0) begin
        log_mismatch($sformatf("verdict %0b with none expected", result_ch.colliding));
      end else begin
        want = verdict_q.pop_front();
        if (result_ch.colliding !== want)
          log_mismatch($sformatf("colliding expected %0b got %0b", want,
                                 result_ch.colliding));
      end
    end
    if (corner_taken) begin
      beats_taken++;
      held_x[corner_ch.box_select][corner_ch.corner_index] = corner_ch.corner_x;
      held_y[corner_ch.box_select][corner_ch.corner_index] = corner_ch.corner_y;
      if (corner_ch.run_test) verdict_q = {verdict_q, boxes_overlap()};
    end
  end

  // Driver: once a beat is taken, offer the next queued corner or idle for a gap or drain.
  always @(negedge clk) begin
    corner_item_t it;
    if (rst_n && (!corner_ch.valid || corner_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        corner_ch.valid <= 1'b0;
      end else if (corner_q.size() > 0 &&
                   !(corner_q[0].hold_for_drain && verdict_q.size() > 0)) begin
        it = corner_q.pop_front();
        corner_ch.box_select   <= it.box;
        corner_ch.corner_index <= it.corner;
        corner_ch.corner_x     <= it.x;
        corner_ch.corner_y     <= it.y;
        corner_ch.run_test     <= it.run;
        corner_ch.valid        <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 8);
      end else begin
        corner_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_ch.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 7);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int total, n, k;
    rst_n                  = 1'b0;
    corner_ch.valid        = 1'b0;
    corner_ch.box_select   = 1'b0;
    corner_ch.corner_index = 2'd0;
    corner_ch.corner_x     = '0;
    corner_ch.corner_y     = '0;
    corner_ch.run_test     = 1'b0;
    result_ch.ready        = 1'b0;

    // Two overlapping squares; every corner is written before the first run.
    push_corner(0, 0, 0, 0, 0);
    push_corner(0, 1, 160, 0, 0);
    push_corner(0, 2, 160, 160, 0);
    push_corner(0, 3, 0, 160, 0);
    push_corner(1, 0, 80, 80, 0);
    push_corner(1, 1, 240, 80, 0);
    push_corner(1, 2, 240, 240, 0);
    push_corner(1, 3, 80, 240, 1);
    // Boxes that share an edge count as colliding.
    push_corner(1, 0, 160, 0, 0);
    push_corner(1, 1, 320, 0, 0);
    push_corner(1, 2, 320, 160, 0);
    push_corner(1, 3, 160, 160, 1);
    // Shift by one LSB to open the smallest gap.
    push_corner(1, 0, 161, 0, 0);
    push_corner(1, 1, 321, 0, 0);
    push_corner(1, 2, 321, 160, 0);
    push_corner(1, 3, 161, 160, 1);
    // Zero-length edge on the second box.
    push_corner(1, 3, 321, 160, 1);
    // First box at the coordinate extremes.
    push_corner(0, 0, -32768, -32768, 0);
    push_corner(0, 1, 32767, -32768, 0);
    push_corner(0, 2, 32767, 32767, 0);
    push_corner(0, 3, -32768, 32767, 1);
    push_corner(1, 0, 32767, -32768, 1);

    // Random part: mostly well-formed tests, some raw noise beats.
    while (corner_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          push_corner($urandom_range(0, 1), $urandom_range(0, 3),
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      $urandom_range(0, 3) == 0);
      end else begin
        queue_box_pair();
      end
    end
    total = corner_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_taken < total) @(negedge clk);
    while (verdict_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    // Any verdict still expected here never arrived.
    while (verdict_q.size() > 0)
      log_mismatch($sformatf("colliding expected %0b got none", verdict_q.pop_front()));
    if (mismatches == 0) begin
      $display("obb_separating_axis_test_test: done, clean");
    end else begin
      $display("obb_separating_axis_test_test: done, errors");
    end
    $finish;
  end

endmodule
